### src/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// shared types, constants and saturation helper for the stencil step block
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = 16;
    localparam int DW       = 32;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COLS = 2'd0;
    localparam t_cfg_idx CFG_ROWS = 2'd1;
    localparam t_cfg_idx CFG_INV  = 2'd2;

    // one classified cell travelling from front to back
    typedef struct packed {
        logic signed [DW-1:0] elev;
        logic signed [DW-1:0] velx;
        logic signed [DW-1:0] vely;
        logic signed [DW-1:0] depth;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 has_prev;
        logic                 interior;
        logic                 last_row;
        logic                 last_col;
    } t_item;

    // saturate to signed 32 bits
    function automatic logic signed [DW-1:0] sat32(input logic signed [47:0] x);
        logic signed [DW-1:0] y;
        if (x > 48'sh0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -48'sh0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[DW-1:0];
        end
        return y;
    endfunction

endpackage

### src/msc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/msc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_front
// config registers, raster cursors and cell classification
// ----------------------------------------------------------------------------
module msc_front import msc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [127:0]      i_s_tdata,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [30:0]       i_cfg_data,
    input  logic              i_fifo_full,
    output logic              o_push,
    output t_item             o_item,
    output logic [30:0]       o_inv
);

    logic [10:0]      r_cols_cfg;
    logic [ROW_W-1:0] r_rows_cfg;
    logic [30:0]      r_inv;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    logic [10:0]      cols_eff;
    logic [ROW_W-1:0] rows_eff;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [10:0]      col_inc;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;
    logic signed [32:0] diff;
    logic             cfg_we;

    assign o_s_tready  = !i_fifo_full;
    assign o_push      = i_s_tvalid && !i_fifo_full;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_inv       = r_inv;

    always_comb begin
        cols_eff = (r_cols_cfg < 11'd3) ? 11'd3 :
                   ((r_cols_cfg > 11'(MAX_COLS)) ? 11'(MAX_COLS) : r_cols_cfg);
        rows_eff = (r_rows_cfg < 16'd3) ? 16'd3 : r_rows_cfg;
        cur_row  = r_row;
        cur_col  = r_col;
        if ((r_row >= rows_eff) || ({1'b0, r_col} >= cols_eff)) begin
            cur_row = '0;
            cur_col = '0;
        end
        diff = 33'(signed'(i_s_tdata[31:0])) - 33'(signed'(i_s_tdata[127:96]));

        o_item.elev     = i_s_tdata[31:0];
        o_item.velx     = i_s_tdata[63:32];
        o_item.vely     = i_s_tdata[95:64];
        o_item.depth    = sat32(48'(diff));
        o_item.row      = cur_row;
        o_item.col      = cur_col;
        o_item.has_prev = (cur_row != '0);
        o_item.last_col = ({1'b0, cur_col} == cols_eff - 11'd1);
        o_item.last_row = (cur_row == rows_eff - 16'd1);
        o_item.interior = (cur_col != '0) && !o_item.last_col && (cur_row >= 16'd2);

        col_inc = {1'b0, cur_col} + 11'd1;
        row_inc = {1'b0, cur_row} + 17'd1;
        n_col   = col_inc[COL_W-1:0];
        n_row   = cur_row;
        if (col_inc >= cols_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= 11'd1024;
            r_rows_cfg <= 16'd1024;
            r_inv      <= 31'd65536;
            r_row      <= '0;
            r_col      <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_COLS: r_cols_cfg <= i_cfg_data[10:0];
                CFG_ROWS: r_rows_cfg <= i_cfg_data[15:0];
                CFG_INV:  r_inv      <= i_cfg_data;
                default:  ;
            endcase
            if ((i_cfg_index == CFG_COLS) || (i_cfg_index == CFG_ROWS) ||
                (i_cfg_index == CFG_INV)) begin
                r_row <= '0;
                r_col <= '0;
            end
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

### src/msc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_fifo
// two entry queue of classified cells between front and back
// ----------------------------------------------------------------------------
module msc_fifo import msc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### src/msc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_back
// line memories, shared multiplier sequencer and output register
// ----------------------------------------------------------------------------
module msc_back import msc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [30:0] i_inv,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RDA   = 14'b00000000000010,
        S_RDB   = 14'b00000000000100,
        S_MUL0  = 14'b00000000001000,
        S_MUL1  = 14'b00000000010000,
        S_MUL2  = 14'b00000000100000,
        S_MUL3  = 14'b00000001000000,
        S_ACC   = 14'b00000010000000,
        S_SCLH  = 14'b00000100000000,
        S_SCLL  = 14'b00001000000000,
        S_COMB  = 14'b00010000000000,
        S_DLT   = 14'b00100000000000,
        S_EMIT1 = 14'b01000000000000,
        S_EMIT2 = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    t_item  r_item;

    logic signed [DW-1:0] r_pe, r_ph, r_pu, r_pv, r_od, r_ov;
    logic signed [DW-1:0] r_left_d, r_left_u;
    logic signed [65:0]   r_prod, r_phi;
    logic signed [43:0]   r_acc;
    logic signed [75:0]   r_full;
    logic signed [41:0]   r_delta;

    logic [DW-1:0] ram_e, ram_d, ram_u, ram_v, ram_od, ram_ov;
    logic          re, we, we_old;
    logic [COL_W-1:0] raddr;

    logic signed [32:0] mul_a, mul_b;
    logic signed [41:0] term;
    logic signed [59:0] full_q;
    logic signed [DW-1:0] res;
    logic          out_free, out_load;
    logic [63:0]   out_data;
    logic          out_last;

    logic          r_out_valid;
    logic [63:0]   r_out_data;
    logic          r_out_last;

    // clamp to +-2^40; callers pass floor(p / 2^16)
    function automatic logic signed [41:0] clamp40(input logic signed [59:0] q);
        logic signed [41:0] y;
        if (q > 60'sh100_0000_0000) begin
            y = 42'sh100_0000_0000;
        end else if (q < -60'sh100_0000_0000) begin
            y = -42'sh100_0000_0000;
        end else begin
            y = q[41:0];
        end
        return y;
    endfunction

    assign term   = clamp40(60'(r_prod >>> 16));
    assign full_q = 60'(r_full >>> 16);

    // line memories
    assign re     = (r_state == S_RDA) || (r_state == S_RDB);
    assign raddr  = (r_state == S_RDB) ? COL_W'(r_item.col + 1'b1) : r_item.col;
    assign we     = (r_state == S_MUL0);
    assign we_old = (r_state == S_MUL0) && r_item.has_prev;

    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_prev_elev (
        .i_clk, .i_we(we), .i_waddr(r_item.col), .i_wdata(r_item.elev),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_e));
    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_prev_depth (
        .i_clk, .i_we(we), .i_waddr(r_item.col), .i_wdata(r_item.depth),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_d));
    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_prev_velx (
        .i_clk, .i_we(we), .i_waddr(r_item.col), .i_wdata(r_item.velx),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_u));
    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_prev_vely (
        .i_clk, .i_we(we), .i_waddr(r_item.col), .i_wdata(r_item.vely),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_v));
    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_older_depth (
        .i_clk, .i_we(we_old), .i_waddr(r_item.col), .i_wdata(r_ph),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_od));
    msc_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_older_vely (
        .i_clk, .i_we(we_old), .i_waddr(r_item.col), .i_wdata(r_pv),
        .i_re(re), .i_raddr(raddr), .o_rdata(ram_ov));

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL0: begin
                mul_a = 33'(r_ph);
                mul_b = 33'(r_left_u) - 33'(signed'(ram_u));
            end
            S_MUL1: begin
                mul_a = 33'(r_pu);
                mul_b = 33'(r_left_d) - 33'(signed'(ram_d));
            end
            S_MUL2: begin
                mul_a = 33'(r_ph);
                mul_b = 33'(r_item.vely) - 33'(r_ov);
            end
            S_MUL3: begin
                mul_a = 33'(r_pv);
                mul_b = 33'(r_item.depth) - 33'(r_od);
            end
            S_SCLH: begin
                mul_a = 33'(signed'(r_acc[43:21]));
                mul_b = signed'({2'b00, i_inv});
            end
            S_SCLL: begin
                mul_a = signed'({12'd0, r_acc[20:0]});
                mul_b = signed'({2'b00, i_inv});
            end
            default: ;
        endcase
    end

    // output selection
    assign out_free = !r_out_valid || i_m_tready;
    always_comb begin
        res = r_item.interior ? sat32(48'(r_pe) - 48'(r_delta)) : r_pe;
        if (r_state == S_EMIT1) begin
            out_data = {6'd0, r_item.col, ROW_W'(r_item.row - 1'b1), res};
            out_last = 1'b0;
        end else begin
            out_data = {6'd0, r_item.col, r_item.row, r_item.elev};
            out_last = r_item.last_col;
        end
    end
    assign out_load = out_free && ((r_state == S_EMIT1) || (r_state == S_EMIT2));
    assign o_pop    = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_MUL0;
            S_MUL0: begin
                if (r_item.has_prev && r_item.interior) n_state = S_MUL1;
                else if (r_item.has_prev)              n_state = S_EMIT1;
                else if (r_item.last_row)              n_state = S_EMIT2;
                else                                   n_state = S_IDLE;
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_ACC;
            S_ACC:   n_state = S_SCLH;
            S_SCLH:  n_state = S_SCLL;
            S_SCLL:  n_state = S_COMB;
            S_COMB:  n_state = S_DLT;
            S_DLT:   n_state = S_EMIT1;
            S_EMIT1: if (out_free) n_state = r_item.last_row ? S_EMIT2 : S_IDLE;
            S_EMIT2: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
        if (r_state == S_RDB) begin
            r_pe <= ram_e;
            r_ph <= ram_d;
            r_pu <= ram_u;
            r_pv <= ram_v;
            r_od <= ram_od;
            r_ov <= ram_ov;
        end
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_MUL0:  r_acc <= '0;
            S_MUL1, S_MUL2, S_MUL3, S_ACC: r_acc <= r_acc + 44'(term);
            default: ;
        endcase
        if (r_state == S_SCLL) r_phi  <= r_prod;
        if (r_state == S_COMB) r_full <= (76'(r_phi) <<< 21) + 76'(r_prod);
        if (r_state == S_DLT)  r_delta <= clamp40(full_q);
        if (out_load) begin
            r_out_data <= out_data;
            r_out_last <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left_d    <= '0;
            r_left_u    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load)        r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
            if (out_load && (r_state == S_EMIT1)) begin
                r_left_d <= r_ph;
                r_left_u <= r_pu;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("pop outside idle");
    a_write_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> ($past(r_state) == S_RDB))
        else $error("line write not right after reads");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_tready))
        else $error("output overwritten");
    a_emit2_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_state == S_EMIT2)) |=> (r_state == S_IDLE))
        else $error("second result not final");

endmodule

### src/mass_conservation_stencil_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mass_conservation_stencil_step
// one epoch of the continuity equation update over a raster streamed grid
// ----------------------------------------------------------------------------
// cells enter in raster order on the slave stream, each a request carrying
// elevation, x and y velocity and slip surface in signed q16.16. a result
// leaves one row late, when the cell below it arrives, with its row and
// column; the last row also echoes each arriving cell as a border result,
// and tlast marks the final cell of the grid. interior cells run the four
// stencil products and the two spacing products through one shared 33x33
// multiplier after two reads of the line memories; cells without a stencil
// skip the products. a two entry queue lets the stream keep arriving while
// the sequencer works, and the output register lets a new cell start while
// a result waits. a config write to cols, rows or inv restarts the frame.
module mass_conservation_stencil_step import msc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // elev_in, vel_x, vel_y, slip_surface
    input  logic [127:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // elev_out, out_row, out_col, zero pad
    output logic [63:0]   o_m_tdata,
    // frame_last
    output logic          o_m_tlast,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [30:0]   i_cfg_data
);

    // front to queue
    logic  push, fifo_full;
    t_item push_item;
    // queue to back
    logic  pop, fifo_valid;
    t_item pop_item;
    logic [30:0] inv;

    msc_front u_front (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_fifo_full(fifo_full), .o_push(push), .o_item(push_item), .o_inv(inv)
    );

    msc_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(push), .i_item(push_item), .o_full(fifo_full),
        .i_pop(pop), .o_valid(fifo_valid), .o_item(pop_item)
    );

    msc_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(fifo_valid), .i_item(pop_item), .o_pop(pop), .i_inv(inv),
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tlast
    );

endmodule
